[rtl/i2rs_pkg.sv]
`default_nettype none

package i2rs_pkg;

    localparam int MAX_BASE = 16;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [1:0] CFG_BASE_LEN   = 2'd2;

    localparam logic [63:0] ALPHA_LOW_RST  = 64'h3736353433323130;
    localparam logic [63:0] ALPHA_HIGH_RST = 64'h0;
    localparam logic [4:0]  BASE_LEN_RST   = 5'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT,
        ST_ERROR
    } i2rs_state_t;

    typedef enum logic [1:0] {
        OSEL_SIGN,
        OSEL_DIGIT,
        OSEL_ERROR
    } i2rs_osel_t;

    typedef struct packed {
        logic       load;
        logic       chk_step;
        logic       div_step;
        logic       out_load;
        i2rs_osel_t out_sel;
    } i2rs_cmd_t;

    typedef struct packed {
        logic len_ok;
        logic sym_bad;
        logic chk_last;
        logic div_last;
        logic quot_zero;
        logic neg;
        logic out_space;
        logic nd_one;
    } i2rs_sts_t;

    function automatic logic [7:0] sym_at(input logic [127:0] alpha, input logic [3:0] idx);
        sym_at = alpha[idx*8 +: 8];
    endfunction

endpackage

`default_nettype wire

[rtl/integer_to_radix_symbols_unit.sv]
// channel  signals                              width
// cfg      cfg_valid cfg_ready cfg_index cfg_data  2 / 64, index 0..2, others ignored
// in       in_valid in_ready number             32 signed
// out      out_valid out_ready symbol status last  8 / 1 / 1
//
// Per item: a transfer, then a check of up to base_length alphabet symbols, then
// one full division of the work word per digit (8 quotient bits per cycle), then
// the symbols out, a sign first if negative, one per cycle while out_ready holds.
// Reset is asynchronous, active low, and restores "01234567" with zero bytes above
// and length 10, an invalid alphabet until the registers are written.
// A stalled output holds the last symbol; the next item is taken once the
// previous one has loaded its final symbol.
`default_nettype none

module integer_to_radix_symbols_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] number,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              symbol,
    output logic                    status,
    output logic                    last
);
    import i2rs_pkg::*;

    i2rs_cmd_t cmd;
    i2rs_sts_t sts;

    assign cfg_ready = 1'b1;

    i2rs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    i2rs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .number    (number),
        .symbol    (symbol),
        .status    (status),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

[rtl/i2rs_ctrl.sv]
`default_nettype none

module i2rs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire i2rs_pkg::i2rs_sts_t sts,
    output i2rs_pkg::i2rs_cmd_t      cmd
);
    import i2rs_pkg::*;

    i2rs_state_t state_reg;
    i2rs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.len_ok || sts.sym_bad)
                begin
                    state_next = ST_ERROR;
                end
                else
                begin
                    cmd.chk_step = 1'b1;
                    if (sts.chk_last)
                    begin
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last && sts.quot_zero)
                begin
                    state_next = sts.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (sts.out_space)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_SIGN;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_space)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_DIGIT;
                    if (sts.nd_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERROR:
            begin
                if (sts.out_space)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_ERROR;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_CHECK))
        else $error("transfer in did not start alphabet check");

    a_divide_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> sts.len_ok)
        else $error("division with invalid radix");

    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && sts.out_space && sts.nd_one) |=> (state_reg == ST_IDLE))
        else $error("last digit did not end the item");

endmodule

`default_nettype wire

[rtl/i2rs_dp.sv]
`default_nettype none

module i2rs_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [63:0]         cfg_data,
    input  wire logic signed [31:0]  number,
    output logic [7:0]               symbol,
    output logic                     status,
    output logic                     last,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire i2rs_pkg::i2rs_cmd_t cmd,
    output i2rs_pkg::i2rs_sts_t      sts
);
    import i2rs_pkg::*;

    logic [63:0]  alpha_low_reg;
    logic [63:0]  alpha_high_reg;
    logic [4:0]   base_len_reg;
    logic [127:0] alpha;

    logic [31:0]  work_reg;
    logic [3:0]   rem_reg;
    logic [1:0]   step_reg;
    logic         neg_reg;
    logic [3:0]   chk_idx_reg;
    logic [5:0]   nd_reg;
    logic [5:0]   nd_m1;
    logic [3:0]   digits_reg [32];

    logic         out_valid_reg;
    logic [7:0]   symbol_reg;
    logic         status_reg;
    logic         last_reg;

    logic [3:0]   div_rem;
    logic [7:0]   div_q;
    logic [31:0]  work_next;
    logic [7:0]   sym_c;
    logic         bad_byte;
    logic         dup;
    logic [31:0]  mag;

    assign alpha     = {alpha_high_reg, alpha_low_reg};
    assign nd_m1     = nd_reg - 6'd1;
    assign mag       = number[31] ? (32'd0 - 32'(number)) : 32'(number);
    assign work_next = {work_reg[23:0], div_q};

    // restoring long division, eight quotient bits per cycle
    always_comb
    begin
        logic [4:0] t;
        logic [3:0] r;
        r     = (step_reg == 2'd0) ? 4'd0 : rem_reg;
        div_q = '0;
        for (int k = 0; k < 8; k++)
        begin
            t = {r, work_reg[31 - k]};
            if (t >= base_len_reg)
            begin
                r            = 4'(t - base_len_reg);
                div_q[7 - k] = 1'b1;
            end
            else
            begin
                r = t[3:0];
            end
        end
        div_rem = r;
    end

    assign sym_c    = sym_at(alpha, chk_idx_reg);
    assign bad_byte = (sym_c <= CH_SPACE) || sym_c[7] || (sym_c == CH_PLUS)
                      || (sym_c == CH_MINUS);

    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < 16; j++)
        begin
            if ((5'(j) > {1'b0, chk_idx_reg}) && (5'(j) < base_len_reg)
                && (sym_at(alpha, 4'(j)) == sym_c))
            begin
                dup = 1'b1;
            end
        end
    end

    always_comb
    begin
        sts.len_ok    = (base_len_reg >= 5'd2) && (base_len_reg <= 5'(MAX_BASE));
        sts.sym_bad   = bad_byte || dup;
        sts.chk_last  = ({1'b0, chk_idx_reg} == (base_len_reg - 5'd1));
        sts.div_last  = (step_reg == 2'd3);
        sts.quot_zero = (work_next == 32'd0);
        sts.neg       = neg_reg;
        sts.out_space = !out_valid_reg || out_ready;
        sts.nd_one    = (nd_reg == 6'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= ALPHA_LOW_RST;
            alpha_high_reg <= ALPHA_HIGH_RST;
            base_len_reg   <= BASE_LEN_RST;
            step_reg       <= '0;
            neg_reg        <= 1'b0;
            chk_idx_reg    <= '0;
            nd_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                    CFG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                    CFG_BASE_LEN:   base_len_reg   <= cfg_data[4:0];
                    default:        ;
                endcase
            end
            if (cmd.load)
            begin
                neg_reg     <= number[31];
                chk_idx_reg <= '0;
                nd_reg      <= '0;
                step_reg    <= '0;
            end
            if (cmd.chk_step)
            begin
                chk_idx_reg <= chk_idx_reg + 4'd1;
            end
            if (cmd.div_step)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    nd_reg <= nd_reg + 6'd1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (cmd.out_sel == OSEL_DIGIT)
                begin
                    nd_reg <= nd_m1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg <= mag;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= div_rem;
            work_reg <= work_next;
            if (step_reg == 2'd3)
            begin
                digits_reg[nd_reg[4:0]] <= div_rem;
            end
        end
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                OSEL_SIGN:
                begin
                    symbol_reg <= CH_MINUS;
                    status_reg <= 1'b0;
                    last_reg   <= 1'b0;
                end
                OSEL_DIGIT:
                begin
                    symbol_reg <= sym_at(alpha, digits_reg[nd_m1[4:0]]);
                    status_reg <= 1'b0;
                    last_reg   <= (nd_reg == 6'd1);
                end
                OSEL_ERROR:
                begin
                    symbol_reg <= 8'd0;
                    status_reg <= 1'b1;
                    last_reg   <= 1'b1;
                end
                default:
                begin
                    symbol_reg <= 8'd0;
                    status_reg <= 1'b1;
                    last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    a_nd_range: assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= 6'd32)
        else $error("digit count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before transfer");

endmodule

`default_nettype wire

[test/testbench.sv]
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import i2rs_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] symbol;
        logic       status;
        logic       last;
    } glyph_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [63:0]        cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic signed [31:0] number    = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         symbol;
    logic               status;
    logic               last;

    // predictor copy of the registers
    logic [63:0] alpha_lo  = ALPHA_LOW_RST;
    logic [63:0] alpha_hi  = ALPHA_HIGH_RST;
    logic [4:0]  radix_len = BASE_LEN_RST;

    glyph_t pending_glyphs[$];
    int     fault_count  = 0;
    int     hold_off_len = 0;
    bit     no_idle      = 1'b0;

    integer_to_radix_symbols_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .number    (number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .status    (status),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_number();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 40) - 20;
            6:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            default:    v = $signed($urandom) >>> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    // expected symbols of one number under the current alphabet
    function automatic void spell_number(input logic [31:0] raw);
        logic [127:0] alpha;
        logic [31:0]  mag;
        logic [31:0]  base;
        logic [7:0]   c;
        logic [3:0]   digits [32];
        int           len;
        int           nd;
        int           i;
        int           j;
        bit           valid;
        glyph_t       g;
        alpha = {alpha_hi, alpha_lo};
        len   = int'(radix_len);
        valid = (len >= 2) && (len <= MAX_BASE);
        for (i = 0; valid && i < len; i++)
        begin
            c = alpha[i*8 +: 8];
            if (c <= CH_SPACE || c >= 8'd128 || c == CH_PLUS || c == CH_MINUS)
                valid = 1'b0;
            for (j = i + 1; j < len; j++)
                if (alpha[j*8 +: 8] == c)
                    valid = 1'b0;
        end
        if (!valid)
        begin
            g.symbol = 8'h00;
            g.status = 1'b1;
            g.last   = 1'b1;
            pending_glyphs.push_back(g);
            return;
        end
        base = len;
        mag  = raw[31] ? (32'd0 - raw) : raw;
        nd   = 0;
        do
        begin
            digits[nd] = 4'(mag % base);
            mag = mag / base;
            nd++;
        end
        while (mag != 0);
        if (raw[31])
        begin
            g.symbol = CH_MINUS;
            g.status = 1'b0;
            g.last   = 1'b0;
            pending_glyphs.push_back(g);
        end
        for (i = nd - 1; i >= 0; i--)
        begin
            j = int'(digits[i]);
            g.symbol = alpha[j*8 +: 8];
            g.status = 1'b0;
            g.last   = (i == 0);
            pending_glyphs.push_back(g);
        end
    endfunction

    function automatic void random_alphabet(input int len, input bit spoil,
                                            output logic [127:0] alpha);
        bit         used [256];
        logic [7:0] c;
        int         i;
        int         k;
        for (i = 0; i < 16; i++)
        begin
            if (i < len)
            begin
                do
                    c = 8'($urandom_range(33, 126));
                while (used[c] || c == CH_PLUS || c == CH_MINUS);
                used[c] = 1'b1;
            end
            else
                c = 8'($urandom_range(0, 255));
            alpha[i*8 +: 8] = c;
        end
        if (spoil)
        begin
            k = $urandom_range(0, len - 1);
            case ($urandom_range(0, 4))
                0:       c = 8'($urandom_range(0, 32));
                1:       c = 8'($urandom_range(128, 255));
                2:       c = CH_PLUS;
                3:       c = CH_MINUS;
                default: c = alpha[((k + 1) % len)*8 +: 8];
            endcase
            alpha[k*8 +: 8] = c;
        end
    endfunction

    task automatic send_number(input logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= v;
        do
            @(posedge clk);
        while (!in_ready);
        spell_number(v);
    endtask

    task automatic wait_drained();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (pending_glyphs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ALPHA_LOW:  alpha_lo  = data;
            CFG_ALPHA_HIGH: alpha_hi  = data;
            CFG_BASE_LEN:   radix_len = data[4:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_alphabet(input logic [127:0] alpha, input logic [63:0] len_data);
        wait_drained();
        write_reg(CFG_ALPHA_LOW, alpha[63:0]);
        write_reg(CFG_ALPHA_HIGH, alpha[127:64]);
        write_reg(CFG_BASE_LEN, len_data);
    endtask

    task automatic test_reset_state();
        send_number(32'd0);
        send_number(32'hFFFF_FFFF);
    endtask

    task automatic test_extreme_values();
        set_alphabet({64'h0000_0000_0000_3938, ALPHA_LOW_RST}, 64'd10);
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'hFFFF_FFFF);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'd10);
        send_number(-32'sd10);
        // binary: longest output
        set_alphabet(128'h3130, 64'd2);
        send_number(32'h8000_0000);
        send_number(32'hFFFF_FFFF);
        send_number(32'h7FFF_FFFF);
        set_alphabet({64'h4645_4443_4241_3938, 64'h3736_3534_3332_3130}, 64'd16);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
    endtask

    task automatic test_alphabet_checks();
        logic [127:0] hex;
        logic [127:0] a;
        hex = {64'h4645_4443_4241_3938, 64'h3736_3534_3332_3130};
        set_alphabet(hex, 64'd0);
        send_number(32'd12345);
        set_alphabet(hex, 64'd1);
        send_number(-32'sd77);
        set_alphabet(hex, 64'd17);
        send_number(32'd12345);
        set_alphabet(hex, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(-32'sd77);
        a = hex;
        a[127:120] = CH_SPACE;
        set_alphabet(a, 64'd16);
        send_number(32'd12345);
        a = hex;
        a[31:24] = 8'h80;
        set_alphabet(a, 64'd16);
        send_number(32'd12345);
        a = hex;
        a[7:0] = CH_PLUS;
        set_alphabet(a, 64'd16);
        send_number(32'd12345);
        a = hex;
        a[79:72] = CH_MINUS;
        set_alphabet(a, 64'd16);
        send_number(-32'sd77);
        a = hex;
        a[127:120] = a[7:0];
        set_alphabet(a, 64'd16);
        send_number(32'd12345);
        // lowest and highest accepted symbols; index 3 is ignored
        a = hex;
        a[7:0]     = 8'h21;
        a[127:120] = 8'h7F;
        set_alphabet(a, 64'd16);
        write_reg(CFG_UNUSED, 64'h2B2B_2B2B_2B2B_2B2B);
        send_number(-32'sd123456);
    endtask

    task automatic test_random_traffic();
        logic [127:0] alpha;
        logic [63:0]  len_data;
        int           p;
        int           n;
        int           len;
        bit           spoil;
        for (p = 0; p < 11; p++)
        begin
            case (p)
                0:       len = 2;
                1:       len = 16;
                default: len = $urandom_range(2, 16);
            endcase
            spoil = (p >= 2) && ($urandom_range(0, 4) == 0);
            random_alphabet(len, spoil, alpha);
            len_data = {$urandom, $urandom};
            if (p == 9)
                len_data[4:0] = 5'($urandom_range(17, 31));
            else if (p == 10)
                len_data[4:0] = 5'($urandom_range(0, 1));
            else
                len_data[4:0] = 5'(len);
            set_alphabet(alpha, len_data);
            no_idle = (p == 4);
            for (n = 0; n < 30; n++)
                send_number(pick_number());
            no_idle = 1'b0;
        end
    endtask

    task automatic test_output_hold_off();
        int n;
        set_alphabet(128'h3130, 64'd2);
        hold_off_len = 400;
        for (n = 0; n < 10; n++)
            send_number(pick_number());
    endtask

    task automatic test_sender_pause();
        logic [127:0] alpha;
        int           r;
        int           n;
        random_alphabet(7, 1'b0, alpha);
        set_alphabet(alpha, 64'd7);
        for (r = 0; r < 2; r++)
        begin
            for (n = 0; n < 5; n++)
                send_number(pick_number());
            wait_drained();
        end
    endtask

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_extreme_values();
        test_alphabet_checks();
        test_random_traffic();
        test_output_hold_off();
        test_sender_pause();
        wait_drained();
        repeat (250) @(posedge clk);
        if (fault_count == 0 && pending_glyphs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                stall_left   = hold_off_len;
                hold_off_len = 0;
            end
            else if (rst_n && out_valid && out_ready)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        glyph_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_glyphs.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected transfer: symbol %02h status %0d last %0d",
                             symbol, status, last);
            end
            else
            begin
                want = pending_glyphs.pop_front();
                if (symbol !== want.symbol || status !== want.status || last !== want.last)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: expected symbol %02h status %0d last %0d, %s",
                                 want.symbol, want.status, want.last,
                                 $sformatf("got symbol %02h status %0d last %0d",
                                           symbol, status, last));
                end
            end
        end
    end

endmodule
